>>> hw/rtl/tlssni_pkg.sv
// Shared types, constants and helpers of the ClientHello server-name extractor.
package tlssni_pkg;

  localparam int WINDOW_BYTES   = 512;
  localparam int MAX_EXTENSIONS = 24;
  localparam int NAME_BUFFER    = 256;
  localparam int QUEUE_DEPTH    = 4;

  localparam int POS_W   = $clog2(WINDOW_BYTES + 1);
  localparam int FIELD_W = $clog2(WINDOW_BYTES + 65536 + 8);
  localparam int CNT_W   = $clog2(MAX_EXTENSIONS + 1);
  localparam int NAME_W  = $clog2(NAME_BUFFER);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CNT_W:0]     cntx_t;
  typedef logic [NAME_W-1:0]  name_t;
  typedef logic [QPTR_W-1:0]  qptr_t;
  typedef logic [QCNT_W-1:0]  qcnt_t;

  localparam field_t WINDOW_F = field_t'(WINDOW_BYTES);

  // Fixed header layout of a TLS handshake record carrying a ClientHello.
  localparam pos_t REC_TYPE_POS  = pos_t'(0);
  localparam pos_t VER_MAJOR_POS = pos_t'(1);
  localparam pos_t HS_TYPE_POS   = pos_t'(5);
  localparam pos_t SID_LEN_POS   = pos_t'(43);

  localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0] VER_MAJOR       = 8'h03;
  localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;

  localparam int EXT_HDR_BYTES  = 4;
  localparam int NAME_LIST_SKIP = 3;
  localparam int NAME_HDR_BYTES = 5;
  localparam int LEN_FIELD_TAIL = 2;

  localparam logic KIND_NAME   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NO_NAME  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_HEAD  = 4'd0,
    PH_CS_HI = 4'd1,
    PH_CS_LO = 4'd2,
    PH_COMP  = 4'd3,
    PH_EL_HI = 4'd4,
    PH_EL_LO = 4'd5,
    PH_EX0   = 4'd6,
    PH_EX1   = 4'd7,
    PH_EX2   = 4'd8,
    PH_EX3   = 4'd9,
    PH_NL_HI = 4'd10,
    PH_NL_LO = 4'd11,
    PH_NAME  = 4'd12
  } phase_t;

  // One queue entry: everything a single payload byte produced.
  typedef struct packed {
    logic       has_byte;
    logic       has_status;
    logic [7:0] name_byte;
    status_t    status;
    logic [7:0] name_length;
  } parse_event_t;

  // True when no further extension header can be started at offset off.
  function automatic logic ext_fail(input cntx_t cnt, input field_t off, input pos_t limit);
    logic too_many;
    logic past_limit;
    logic past_window;
    too_many    = (cnt >= cntx_t'(MAX_EXTENSIONS));
    past_limit  = (off + field_t'(EXT_HDR_BYTES) > field_t'(limit));
    past_window = (off + field_t'(EXT_HDR_BYTES) >= WINDOW_F);
    return too_many || past_limit || past_window;
  endfunction

endpackage

>>> hw/rtl/tls_client_hello_sni_extractor.sv
// Top level of the TLS ClientHello server-name extractor.
// The block takes one payload byte per cycle while in_stall is low; the parser in the
// front end decides each byte in the cycle it is accepted and writes what that byte
// produced into a four-entry event queue. in_stall rises only when that queue is full.
// The back end turns each event into transfers from a single output register: a name
// byte is one transfer, and the closing status is one more, so a name of N bytes yields
// N+1 transfers. A result passes through the event queue and the output register.
// Every payload, marked by end_of_payload on its final byte, yields exactly one status
// transfer with last set. name_limit is written through cfg_write_enable and
// cfg_write_data and should only change while no payload is in progress.
module tls_client_hello_sni_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_enable,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] payload_byte,
  input  logic       end_of_payload,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] name_byte,
  output logic [7:0] name_length,
  output logic [2:0] status,
  output logic       last
);

  logic                     ev_push;
  tlssni_pkg::parse_event_t ev;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_not_empty;
  tlssni_pkg::parse_event_t q_head;

  tlssni_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .payload_byte     (payload_byte),
    .end_of_payload   (end_of_payload),
    .q_full           (q_full),
    .ev_push          (ev_push),
    .ev               (ev)
  );

  tlssni_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (ev),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  tlssni_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .name_byte   (name_byte),
    .name_length (name_length),
    .status      (status),
    .last        (last)
  );

endmodule

>>> hw/rtl/tlssni_front.sv
// Front end: accepts payload bytes, walks the ClientHello and classifies each byte.
module tlssni_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_enable,
  input  logic [7:0]              cfg_write_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              payload_byte,
  input  logic                    end_of_payload,
  input  logic                    q_full,
  output logic                    ev_push,
  output tlssni_pkg::parse_event_t ev
);

  logic [7:0]            name_limit;
  tlssni_pkg::pos_t      byte_position;
  tlssni_pkg::phase_t    parse_phase;
  tlssni_pkg::field_t    next_field_position;
  logic [7:0]            length_high;
  tlssni_pkg::pos_t      extensions_limit;
  tlssni_pkg::cnt_t      extension_count;
  tlssni_pkg::name_t     names_left;
  tlssni_pkg::name_t     held_length;
  logic                  type_nonzero;
  logic                  outcome_sent;

  tlssni_pkg::pos_t      byte_position_next;
  tlssni_pkg::phase_t    parse_phase_next;
  tlssni_pkg::field_t    next_field_position_next;
  logic [7:0]            length_high_next;
  tlssni_pkg::pos_t      extensions_limit_next;
  tlssni_pkg::cnt_t      extension_count_next;
  tlssni_pkg::name_t     names_left_next;
  tlssni_pkg::name_t     held_length_next;
  logic                  type_nonzero_next;
  logic                  outcome_sent_next;

  // Per-byte decision.
  logic                  fin;
  tlssni_pkg::status_t   fin_status;
  logic                  emit;
  logic                  eop_fin;
  tlssni_pkg::status_t   eop_status;

  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin : next_state
    tlssni_pkg::field_t p_ext;
    tlssni_pkg::field_t off;
    tlssni_pkg::field_t lim;
    tlssni_pkg::field_t nl_end;
    tlssni_pkg::cntx_t  cnt_inc;
    tlssni_pkg::pos_t   lim_sat;
    logic [15:0]        len16;
    logic               at_field;
    logic               head_bad;

    p_ext    = tlssni_pkg::field_t'(byte_position);
    off      = '0;
    lim      = '0;
    nl_end   = '0;
    cnt_inc  = '0;
    lim_sat  = '0;
    len16    = {length_high, payload_byte};
    at_field = (p_ext == next_field_position);
    head_bad = '0;

    byte_position_next       = byte_position;
    parse_phase_next         = parse_phase;
    next_field_position_next = next_field_position;
    length_high_next         = length_high;
    extensions_limit_next    = extensions_limit;
    extension_count_next     = extension_count;
    names_left_next          = names_left;
    held_length_next         = held_length;
    type_nonzero_next        = type_nonzero;
    outcome_sent_next        = outcome_sent;
    fin                      = 1'b0;
    fin_status               = tlssni_pkg::ST_FOUND;
    emit                     = 1'b0;
    eop_fin                  = 1'b0;
    eop_status               = tlssni_pkg::ST_TRUNC;

    if (!outcome_sent) begin
      case (parse_phase)
        tlssni_pkg::PH_HEAD: begin
          head_bad =
            (byte_position == tlssni_pkg::REC_TYPE_POS &&
             payload_byte != tlssni_pkg::REC_HANDSHAKE) ||
            (byte_position == tlssni_pkg::VER_MAJOR_POS &&
             payload_byte != tlssni_pkg::VER_MAJOR) ||
            (byte_position == tlssni_pkg::HS_TYPE_POS &&
             payload_byte != tlssni_pkg::HS_CLIENT_HELLO);
          if (head_bad) begin
            fin        = 1'b1;
            fin_status = tlssni_pkg::ST_SHORT;
          end else if (byte_position == tlssni_pkg::SID_LEN_POS) begin
            // The session id length byte: skip the id itself.
            off = p_ext + tlssni_pkg::field_t'(1) + tlssni_pkg::field_t'(payload_byte);
            if (off + tlssni_pkg::field_t'(tlssni_pkg::LEN_FIELD_TAIL) >=
                tlssni_pkg::WINDOW_F) begin
              fin        = 1'b1;
              fin_status = tlssni_pkg::ST_NO_NAME;
            end else begin
              next_field_position_next = off;
              parse_phase_next         = tlssni_pkg::PH_CS_HI;
            end
          end
        end
        tlssni_pkg::PH_CS_HI, tlssni_pkg::PH_EL_HI, tlssni_pkg::PH_NL_HI,
        tlssni_pkg::PH_EX2: begin
          if (at_field) begin
            length_high_next         = payload_byte;
            next_field_position_next = p_ext + tlssni_pkg::field_t'(1);
            case (parse_phase)
              tlssni_pkg::PH_CS_HI: parse_phase_next = tlssni_pkg::PH_CS_LO;
              tlssni_pkg::PH_EL_HI: parse_phase_next = tlssni_pkg::PH_EL_LO;
              tlssni_pkg::PH_NL_HI: parse_phase_next = tlssni_pkg::PH_NL_LO;
              default:              parse_phase_next = tlssni_pkg::PH_EX3;
            endcase
          end
        end
        tlssni_pkg::PH_CS_LO: begin
          if (at_field) begin
            off = p_ext + tlssni_pkg::field_t'(1) + tlssni_pkg::field_t'(len16);
            if (off >= tlssni_pkg::WINDOW_F) begin
              fin        = 1'b1;
              fin_status = tlssni_pkg::ST_NO_NAME;
            end else begin
              next_field_position_next = off;
              parse_phase_next         = tlssni_pkg::PH_COMP;
            end
          end
        end
        tlssni_pkg::PH_COMP: begin
          if (at_field) begin
            off = p_ext + tlssni_pkg::field_t'(1) + tlssni_pkg::field_t'(payload_byte);
            if (off + tlssni_pkg::field_t'(tlssni_pkg::LEN_FIELD_TAIL) >=
                tlssni_pkg::WINDOW_F) begin
              fin        = 1'b1;
              fin_status = tlssni_pkg::ST_NO_NAME;
            end else begin
              next_field_position_next = off;
              parse_phase_next         = tlssni_pkg::PH_EL_HI;
            end
          end
        end
        tlssni_pkg::PH_EL_LO: begin
          if (at_field) begin
            off = p_ext + tlssni_pkg::field_t'(1);
            lim = off + tlssni_pkg::field_t'(len16);
            // The extensions end is clipped to the window.
            lim_sat = (lim > tlssni_pkg::WINDOW_F) ?
                      tlssni_pkg::pos_t'(tlssni_pkg::WINDOW_BYTES) :
                      tlssni_pkg::pos_t'(lim);
            extensions_limit_next = lim_sat;
            extension_count_next  = '0;
            if (tlssni_pkg::ext_fail('0, off, lim_sat)) begin
              fin        = 1'b1;
              fin_status = tlssni_pkg::ST_NO_NAME;
            end else begin
              next_field_position_next = off;
              parse_phase_next         = tlssni_pkg::PH_EX0;
            end
          end
        end
        tlssni_pkg::PH_EX0: begin
          if (at_field) begin
            type_nonzero_next        = (payload_byte != 8'd0);
            next_field_position_next = p_ext + tlssni_pkg::field_t'(1);
            parse_phase_next         = tlssni_pkg::PH_EX1;
          end
        end
        tlssni_pkg::PH_EX1: begin
          if (at_field) begin
            type_nonzero_next        = type_nonzero || (payload_byte != 8'd0);
            next_field_position_next = p_ext + tlssni_pkg::field_t'(1);
            parse_phase_next         = tlssni_pkg::PH_EX2;
          end
        end
        tlssni_pkg::PH_EX3: begin
          if (at_field) begin
            off = p_ext + tlssni_pkg::field_t'(1);
            if (!type_nonzero) begin
              // Server-name extension: jump over the list length and name type.
              if (off + tlssni_pkg::field_t'(tlssni_pkg::NAME_HDR_BYTES) >=
                  tlssni_pkg::WINDOW_F) begin
                fin        = 1'b1;
                fin_status = tlssni_pkg::ST_NO_NAME;
              end else begin
                next_field_position_next =
                  off + tlssni_pkg::field_t'(tlssni_pkg::NAME_LIST_SKIP);
                parse_phase_next = tlssni_pkg::PH_NL_HI;
              end
            end else begin
              cnt_inc              = tlssni_pkg::cntx_t'(extension_count) +
                                     tlssni_pkg::cntx_t'(1);
              extension_count_next = tlssni_pkg::cnt_t'(cnt_inc);
              lim                  = off + tlssni_pkg::field_t'(len16);
              if (tlssni_pkg::ext_fail(cnt_inc, lim, extensions_limit)) begin
                fin        = 1'b1;
                fin_status = tlssni_pkg::ST_NO_NAME;
              end else begin
                next_field_position_next = lim;
                parse_phase_next         = tlssni_pkg::PH_EX0;
              end
            end
          end
        end
        tlssni_pkg::PH_NL_LO: begin
          if (at_field) begin
            off    = p_ext + tlssni_pkg::field_t'(1);
            nl_end = off + tlssni_pkg::field_t'(len16);
            if (len16 == 16'd0 ||
                len16 > 16'(tlssni_pkg::NAME_BUFFER - 1) ||
                len16 > {8'd0, name_limit} ||
                nl_end > tlssni_pkg::field_t'(extensions_limit) ||
                nl_end >= tlssni_pkg::WINDOW_F) begin
              fin        = 1'b1;
              fin_status = tlssni_pkg::ST_BAD_LEN;
            end else begin
              held_length_next         = tlssni_pkg::name_t'(len16);
              names_left_next          = tlssni_pkg::name_t'(len16);
              next_field_position_next = off;
              parse_phase_next         = tlssni_pkg::PH_NAME;
            end
          end
        end
        tlssni_pkg::PH_NAME: begin
          if (at_field) begin
            emit                     = 1'b1;
            names_left_next          = names_left - tlssni_pkg::name_t'(1);
            next_field_position_next = p_ext + tlssni_pkg::field_t'(1);
            if (names_left == tlssni_pkg::name_t'(1)) begin
              fin        = 1'b1;
              fin_status = tlssni_pkg::ST_FOUND;
            end
          end
        end
        default: begin
          fin        = 1'b1;
          fin_status = tlssni_pkg::ST_NO_NAME;
        end
      endcase

      if (end_of_payload && !fin) begin
        eop_fin    = 1'b1;
        eop_status = (parse_phase_next == tlssni_pkg::PH_HEAD) ?
                     tlssni_pkg::ST_SHORT : tlssni_pkg::ST_TRUNC;
      end
    end

    if (end_of_payload) begin
      byte_position_next       = '0;
      parse_phase_next         = tlssni_pkg::PH_HEAD;
      next_field_position_next = '0;
      length_high_next         = '0;
      extensions_limit_next    = '0;
      extension_count_next     = '0;
      names_left_next          = '0;
      held_length_next         = '0;
      type_nonzero_next        = 1'b0;
      outcome_sent_next        = 1'b0;
    end else begin
      outcome_sent_next = outcome_sent || fin;
      if (byte_position < tlssni_pkg::pos_t'(tlssni_pkg::WINDOW_BYTES)) begin
        byte_position_next = byte_position + tlssni_pkg::pos_t'(1);
      end
    end
  end

  always_comb begin : event_out
    ev.has_byte    = emit;
    ev.has_status  = fin || eop_fin;
    ev.name_byte   = payload_byte;
    ev.status      = fin ? fin_status : eop_status;
    ev.name_length = (fin && fin_status == tlssni_pkg::ST_FOUND) ?
                     8'(held_length) : 8'd0;
    ev_push        = accept && (emit || fin || eop_fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= 8'd255;
    end else if (cfg_write_enable) begin
      name_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      parse_phase         <= tlssni_pkg::PH_HEAD;
      next_field_position <= '0;
      length_high         <= '0;
      extensions_limit    <= '0;
      extension_count     <= '0;
      names_left          <= '0;
      held_length         <= '0;
      type_nonzero        <= 1'b0;
      outcome_sent        <= 1'b0;
    end else if (accept) begin
      byte_position       <= byte_position_next;
      parse_phase         <= parse_phase_next;
      next_field_position <= next_field_position_next;
      length_high         <= length_high_next;
      extensions_limit    <= extensions_limit_next;
      extension_count     <= extension_count_next;
      names_left          <= names_left_next;
      held_length         <= held_length_next;
      type_nonzero        <= type_nonzero_next;
      outcome_sent        <= outcome_sent_next;
    end
  end

endmodule

>>> hw/rtl/tlssni_queue.sv
// Short event queue between the parsing front end and the result back end.
module tlssni_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  tlssni_pkg::parse_event_t push_data,
  output logic                     full,
  input  logic                     pop,
  output logic                     not_empty,
  output tlssni_pkg::parse_event_t head
);

  tlssni_pkg::parse_event_t entries [tlssni_pkg::QUEUE_DEPTH];
  tlssni_pkg::qptr_t        wr_ptr;
  tlssni_pkg::qptr_t        rd_ptr;
  tlssni_pkg::qcnt_t        fill;

  logic do_push;
  logic do_pop;

  assign full      = (fill == tlssni_pkg::qcnt_t'(tlssni_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic tlssni_pkg::qptr_t ptr_inc(input tlssni_pkg::qptr_t ptr);
    return (ptr == tlssni_pkg::qptr_t'(tlssni_pkg::QUEUE_DEPTH - 1)) ?
           '0 : ptr + tlssni_pkg::qptr_t'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + tlssni_pkg::qcnt_t'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - tlssni_pkg::qcnt_t'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tlssni_back.sv
// Back end: expands queued events into name-byte and status transfers.
module tlssni_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_not_empty,
  input  tlssni_pkg::parse_event_t q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     kind,
  output logic [7:0]               name_byte,
  output logic [7:0]               name_length,
  output logic [2:0]               status,
  output logic                     last
);

  logic                out_valid_r;
  logic                out_kind;
  logic [7:0]          out_byte;
  logic [7:0]          out_len;
  tlssni_pkg::status_t out_status;

  // A status that still follows the name byte now in the output register.
  logic                pend_valid;
  tlssni_pkg::status_t pend_status;
  logic [7:0]          pend_len;

  logic slot_free;

  assign slot_free   = !out_valid_r || !out_stall;
  assign q_pop       = slot_free && !pend_valid && q_not_empty;

  assign out_valid   = out_valid_r;
  assign kind        = out_kind;
  assign name_byte   = out_byte;
  assign name_length = out_len;
  assign status      = out_status;
  assign last        = (out_kind == tlssni_pkg::KIND_STATUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      pend_valid  <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        out_valid_r <= 1'b1;
        pend_valid  <= 1'b0;
      end else if (q_not_empty) begin
        out_valid_r <= 1'b1;
        pend_valid  <= q_head.has_byte && q_head.has_status;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        out_kind   <= tlssni_pkg::KIND_STATUS;
        out_byte   <= 8'd0;
        out_len    <= pend_len;
        out_status <= pend_status;
      end else if (q_not_empty) begin
        pend_status <= q_head.status;
        pend_len    <= q_head.name_length;
        if (q_head.has_byte) begin
          out_kind   <= tlssni_pkg::KIND_NAME;
          out_byte   <= q_head.name_byte;
          out_len    <= 8'd0;
          out_status <= tlssni_pkg::ST_FOUND;
        end else begin
          out_kind   <= tlssni_pkg::KIND_STATUS;
          out_byte   <= 8'd0;
          out_len    <= q_head.name_length;
          out_status <= q_head.status;
        end
      end
    end
  end

endmodule

>>> tb/tb_tls_client_hello_sni_extractor.sv
// Self-checking testbench for the TLS ClientHello server-name extractor.
module tb_tls_client_hello_sni_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import tlssni_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BYTES = 435;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } tcp_byte_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic [7:0] name_length;
    status_t    status;
    logic       last;
  } sni_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_enable = 1'b0;
  logic [7:0] cfg_write_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] payload_byte = 8'h00;
  logic       end_of_payload = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [7:0] name_byte;
  logic [7:0] name_length;
  logic [2:0] status;
  logic       last;

  tls_client_hello_sni_extractor dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .payload_byte     (payload_byte),
    .end_of_payload   (end_of_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .name_byte        (name_byte),
    .name_length      (name_length),
    .status           (status),
    .last             (last)
  );

  tcp_byte_t   bytes_to_send[$];
  sni_result_t name_results_due[$];
  logic [7:0]  frame[$];
  logic [7:0]  ext_bytes[$];

  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 48;
  int          mismatches = 0;
  int          checked = 0;
  int          frames_queued = 0;
  int          bytes_queued = 0;
  int          limit_writes = 0;
  int          stuck_cycles = 0;
  int          status_tally[5];

  // Mirror of the parser state.
  logic [7:0]  name_limit_cfg = 8'd255;
  pos_t        pos;
  phase_t      phase;
  field_t      next_pos;
  logic [15:0] len_acc;
  field_t      ext_end;
  cnt_t        ext_seen;
  name_t       name_todo;
  name_t       held_len;
  logic        decided;
  logic        type_set;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic clear_parse();
    pos = '0;
    phase = PH_HEAD;
    next_pos = '0;
    len_acc = '0;
    ext_end = '0;
    ext_seen = '0;
    name_todo = '0;
    held_len = '0;
    decided = 1'b0;
    type_set = 1'b0;
  endtask

  task automatic post_result(input logic k, input logic [7:0] b, input logic [7:0] len,
                             input status_t s);
    sni_result_t r;
    r.kind = k;
    r.name_byte = b;
    r.name_length = len;
    r.status = s;
    r.last = k;
    name_results_due.push_back(r);
    if (k == KIND_STATUS) begin
      decided = 1'b1;
      status_tally[s]++;
    end
  endtask

  task automatic start_extension(input field_t off);
    if (ext_seen >= MAX_EXTENSIONS || off + EXT_HDR_BYTES > ext_end ||
        off + EXT_HDR_BYTES >= WINDOW_BYTES) begin
      post_result(KIND_STATUS, 8'h00, 8'h00, ST_NO_NAME);
    end else begin
      next_pos = off;
      phase = PH_EX0;
    end
  endtask

  // Advances the mirror by one accepted payload byte and queues what it yields.
  task automatic track_payload_byte(input logic [7:0] b, input logic eop);
    field_t      off;
    field_t      lim;
    logic [15:0] nl;
    if (!decided) begin
      if (phase == PH_HEAD) begin
        if ((pos == REC_TYPE_POS && b != REC_HANDSHAKE) ||
            (pos == VER_MAJOR_POS && b != VER_MAJOR) ||
            (pos == HS_TYPE_POS && b != HS_CLIENT_HELLO)) begin
          post_result(KIND_STATUS, 8'h00, 8'h00, ST_SHORT);
        end else if (pos == SID_LEN_POS) begin
          off = field_t'(SID_LEN_POS) + 1 + b;
          if (off + LEN_FIELD_TAIL >= WINDOW_BYTES) begin
            post_result(KIND_STATUS, 8'h00, 8'h00, ST_NO_NAME);
          end else begin
            next_pos = off;
            phase = PH_CS_HI;
          end
        end
      end else if (field_t'(pos) == next_pos) begin
        off = field_t'(pos) + 1;
        case (phase)
          PH_CS_HI, PH_EL_HI, PH_NL_HI, PH_EX2: begin
            len_acc = {b, 8'h00};
            phase = phase_t'(phase + 1);
            next_pos = off;
          end
          PH_CS_LO: begin
            lim = off + (len_acc | b);
            if (lim >= WINDOW_BYTES) begin
              post_result(KIND_STATUS, 8'h00, 8'h00, ST_NO_NAME);
            end else begin
              next_pos = lim;
              phase = PH_COMP;
            end
          end
          PH_COMP: begin
            lim = off + b;
            if (lim + LEN_FIELD_TAIL >= WINDOW_BYTES) begin
              post_result(KIND_STATUS, 8'h00, 8'h00, ST_NO_NAME);
            end else begin
              next_pos = lim;
              phase = PH_EL_HI;
            end
          end
          PH_EL_LO: begin
            lim = off + (len_acc | b);
            ext_end = (lim > WINDOW_BYTES) ? WINDOW_F : lim;
            ext_seen = '0;
            start_extension(off);
          end
          PH_EX0: begin
            type_set = (b != 8'h00);
            phase = PH_EX1;
            next_pos = off;
          end
          PH_EX1: begin
            if (b != 8'h00) type_set = 1'b1;
            phase = PH_EX2;
            next_pos = off;
          end
          PH_EX3: begin
            if (!type_set) begin
              if (off + NAME_HDR_BYTES >= WINDOW_BYTES) begin
                post_result(KIND_STATUS, 8'h00, 8'h00, ST_NO_NAME);
              end else begin
                next_pos = off + NAME_LIST_SKIP;
                phase = PH_NL_HI;
              end
            end else begin
              ext_seen++;
              start_extension(off + (len_acc | b));
            end
          end
          PH_NL_LO: begin
            nl = len_acc | b;
            if (nl == 0 || nl > NAME_BUFFER - 1 || nl > name_limit_cfg ||
                off + nl > ext_end || off + nl >= WINDOW_BYTES) begin
              post_result(KIND_STATUS, 8'h00, 8'h00, ST_BAD_LEN);
            end else begin
              held_len = nl[7:0];
              name_todo = nl[7:0];
              next_pos = off;
              phase = PH_NAME;
            end
          end
          PH_NAME: begin
            post_result(KIND_NAME, b, 8'h00, ST_FOUND);
            name_todo--;
            next_pos = off;
            if (name_todo == 0) post_result(KIND_STATUS, 8'h00, held_len, ST_FOUND);
          end
          default: post_result(KIND_STATUS, 8'h00, 8'h00, ST_NO_NAME);
        endcase
      end
    end
    if (eop) begin
      if (!decided)
        post_result(KIND_STATUS, 8'h00, 8'h00, (phase == PH_HEAD) ? ST_SHORT : ST_TRUNC);
      clear_parse();
    end else if (pos < WINDOW_BYTES) begin
      pos++;
    end
  endtask

  task automatic add_other_ext();
    int t;
    int n;
    t = $urandom_range(1, 65535);
    n = $urandom_range(6);
    ext_bytes.push_back(8'(t >> 8));
    ext_bytes.push_back(8'(t));
    ext_bytes.push_back(8'h00);
    ext_bytes.push_back(8'(n));
    repeat (n) ext_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Builds a ClientHello in frame. A negative name_n leaves out the server-name extension;
  // decl_n is the declared name length and name_n the name bytes actually present.
  task automatic build_hello(input int sid_n, input int cs_n, input int comp_n, input int pre_n,
                             input int decl_n, input int name_n, input int post_n,
                             input int slack);
    int ext_total;
    frame = {};
    ext_bytes = {};
    frame.push_back(REC_HANDSHAKE);
    frame.push_back(VER_MAJOR);
    repeat (3) frame.push_back(8'($urandom_range(255)));
    frame.push_back(HS_CLIENT_HELLO);
    repeat (SID_LEN_POS - HS_TYPE_POS - 1) frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'(sid_n));
    repeat (sid_n) frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'(cs_n >> 8));
    frame.push_back(8'(cs_n));
    repeat (cs_n) frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'(comp_n));
    repeat (comp_n) frame.push_back(8'($urandom_range(255)));
    repeat (pre_n) add_other_ext();
    if (name_n >= 0) begin
      ext_bytes.push_back(8'h00);
      ext_bytes.push_back(8'h00);
      ext_bytes.push_back(8'((decl_n + NAME_HDR_BYTES) >> 8));
      ext_bytes.push_back(8'(decl_n + NAME_HDR_BYTES));
      ext_bytes.push_back(8'((decl_n + NAME_LIST_SKIP) >> 8));
      ext_bytes.push_back(8'(decl_n + NAME_LIST_SKIP));
      ext_bytes.push_back(8'h00);
      ext_bytes.push_back(8'(decl_n >> 8));
      ext_bytes.push_back(8'(decl_n));
      repeat (name_n) ext_bytes.push_back(8'($urandom_range(255)));
    end
    repeat (post_n) add_other_ext();
    ext_total = ext_bytes.size() + slack;
    if (ext_total < 0) ext_total = 0;
    if (ext_total > 65535) ext_total = 65535;
    frame.push_back(8'(ext_total >> 8));
    frame.push_back(8'(ext_total));
    frame = {frame, ext_bytes};
  endtask

  task automatic queue_frame();
    tcp_byte_t sb;
    foreach (frame[i]) begin
      sb.data = frame[i];
      sb.eop = (i == frame.size() - 1);
      bytes_to_send.push_back(sb);
    end
    frames_queued++;
    bytes_queued += frame.size();
  endtask

  task automatic settle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || name_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_name_limit(input logic [7:0] v);
    settle();
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    name_limit_cfg = v;
    limit_writes++;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    build_hello(0, 2, 1, 0, 1, 1, 0, 0);
    queue_frame();
    build_hello(32, 4, 1, 2, 255, 255, 1, 0);
    queue_frame();
    build_hello(0, 2, 1, 1, 256, 8, 0, 0);
    queue_frame();
    build_hello(0, 2, 1, 0, 0, 0, 0, 0);
    queue_frame();
    // Wrong record type on a one-byte payload, then a lone valid first byte.
    frame = {8'h00};
    queue_frame();
    frame = {REC_HANDSHAKE};
    queue_frame();
    build_hello(0, 2, 1, 0, 4, 4, 0, 0);
    frame[VER_MAJOR_POS] = ~VER_MAJOR;
    queue_frame();
    build_hello(0, 2, 1, 0, 4, 4, 0, 0);
    frame[HS_TYPE_POS] = ~HS_CLIENT_HELLO;
    queue_frame();
    build_hello(0, 2, 1, 0, 4, 4, 0, 0);
    frame = frame[0:20];
    queue_frame();
    // Ends right on the session id length byte.
    build_hello(0, 2, 1, 1, 6, 6, 0, 0);
    frame = frame[0:SID_LEN_POS];
    queue_frame();
    build_hello(0, 2, 1, 1, 6, 6, 0, 0);
    frame = frame[0:frame.size() - 3];
    queue_frame();
    build_hello(0, 2, 1, 3, 0, -1, 0, 0);
    queue_frame();
    build_hello(0, 2, 1, 26, 4, 4, 0, 0);
    queue_frame();
    // Cipher suites run past the window; no extension header fits; name header at the edge.
    build_hello(255, 300, 1, 0, 4, 4, 0, 0);
    queue_frame();
    build_hello(32, 428, 1, 0, 4, 4, 0, 0);
    queue_frame();
    build_hello(32, 422, 1, 0, 4, 4, 0, 0);
    queue_frame();
    // The name either ends one byte short of the window edge or reaches it.
    build_hello(32, 380, 1, 0, 40, 40, 0, 0);
    queue_frame();
    build_hello(32, 380, 1, 0, 41, 41, 0, 0);
    queue_frame();
    build_hello(0, 2, 1, 0, 6, 6, 0, -3);
    queue_frame();
    // Oversized extensions length and a payload longer than the window.
    build_hello(0, 2, 1, 1, 0, -1, 0, 60000);
    while (frame.size() < 600) frame.push_back(8'($urandom_range(255)));
    queue_frame();
    set_name_limit(8'd0);
    build_hello(0, 2, 1, 0, 5, 5, 0, 0);
    queue_frame();
    set_name_limit(8'd1);
    build_hello(0, 2, 1, 0, 1, 1, 0, 0);
    queue_frame();
    build_hello(0, 2, 1, 0, 2, 2, 0, 0);
    queue_frame();
    set_name_limit(8'd8);
    build_hello(0, 2, 1, 1, 8, 8, 1, 0);
    queue_frame();
    build_hello(0, 2, 1, 1, 9, 9, 1, 0);
    queue_frame();
    set_name_limit(8'd255);
  endtask

  // Mostly well-formed hellos with random content; the rest is broken or noise.
  task automatic queue_random_frames(input int budget);
    int start_bytes;
    int sel, sid, cs, comp, pre, post, nm, decl, cut, idx;
    start_bytes = bytes_queued;
    while (bytes_queued - start_bytes < budget) begin
      sid = ($urandom_range(3) == 0) ? $urandom_range(32) : 0;
      cs = 2 * $urandom_range(1, 8);
      comp = $urandom_range(1, 2);
      pre = $urandom_range(3);
      post = $urandom_range(2);
      nm = $urandom_range(1, 24);
      sel = $urandom_range(99);
      if (sel < 55) begin
        build_hello(sid, cs, comp, pre, nm, nm, post,
                    ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
        repeat ($urandom_range(3)) frame.push_back(8'($urandom_range(255)));
      end else if (sel < 65) begin
        build_hello(sid, cs, comp, pre, nm, nm, post, 0);
        cut = $urandom_range(1, frame.size());
        frame = frame[0:cut - 1];
      end else if (sel < 72) begin
        build_hello(sid, cs, comp, pre + 1, 0, -1, post,
                    ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 16));
      end else if (sel < 80) begin
        case ($urandom_range(3))
          0: build_hello(sid, cs, comp, pre, 0, 0, post, 0);
          1: build_hello(sid, cs, comp, pre, $urandom_range(256, 65535), nm, post, 0);
          2: begin
            decl = name_limit_cfg + 1;
            build_hello(sid, cs, comp, pre, decl, (decl > 255) ? nm : decl, post, 0);
          end
          default: build_hello(sid, cs, comp, pre, nm, nm, 0, -$urandom_range(1, nm));
        endcase
      end else if (sel < 84) begin
        build_hello(sid, cs, comp, $urandom_range(20, 26), nm, nm, 0, 0);
      end else if (sel < 92) begin
        frame = {};
        repeat ($urandom_range(1, 10)) frame.push_back(8'($urandom_range(255)));
        if ($urandom_range(1) == 1) frame[0] = REC_HANDSHAKE;
      end else begin
        build_hello(sid, cs, comp, pre, nm, nm, post, 0);
        case ($urandom_range(2))
          0: idx = REC_TYPE_POS;
          1: idx = VER_MAJOR_POS;
          default: idx = HS_TYPE_POS;
        endcase
        frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
      end
      queue_frame();
    end
  endtask

  initial begin
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    queue_random_frames(RANDOM_BYTES);
    settle();
    send_idle_pct = 48;
    recv_idle_pct = 13;
    set_name_limit(8'($urandom_range(4, 40)));
    queue_random_frames(RANDOM_BYTES);
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_name_limit(8'd255);
    queue_random_frames(RANDOM_BYTES);
    settle();
    $display("covered %0d payloads (%0d bytes), %0d results checked, %0d name_limit writes",
             frames_queued, bytes_queued, checked, limit_writes);
    $display("outcomes: found %0d, short %0d, no name %0d, bad length %0d, truncated %0d",
             status_tally[ST_FOUND], status_tally[ST_SHORT], status_tally[ST_NO_NAME],
             status_tally[ST_BAD_LEN], status_tally[ST_TRUNC]);
    if (mismatches == 0) begin
      $display("tls_client_hello_sni_extractor regression: pass");
    end else begin
      $display("tls_client_hello_sni_extractor regression: fail");
    end
    $finish;
  end

  // Input driver: a stalled transfer holds its payload until it is taken.
  always @(posedge clk) begin
    tcp_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_payload_byte(payload_byte, end_of_payload);
      if (!in_valid || !in_stall) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          payload_byte <= nxt.data;
          end_of_payload <= nxt.eop;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stall.
  always @(posedge clk) begin
    sni_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (name_results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected transfer kind %0d status %0d", kind, status));
        end else begin
          want = name_results_due.pop_front();
          checked++;
          if (kind !== want.kind)
            flag_mismatch($sformatf("result %0d kind %0d, want %0d", checked, kind, want.kind));
          if (name_byte !== want.name_byte)
            flag_mismatch($sformatf("result %0d name_byte %0h, want %0h", checked, name_byte,
                                    want.name_byte));
          if (name_length !== want.name_length)
            flag_mismatch($sformatf("result %0d name_length %0d, want %0d", checked,
                                    name_length, want.name_length));
          if (status !== want.status)
            flag_mismatch($sformatf("result %0d status %0d, want %0d", checked, status,
                                    want.status));
          if (last !== want.last)
            flag_mismatch($sformatf("result %0d last %0d, want %0d", checked, last, want.last));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Ends the run when neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding", stuck_cycles,
               name_results_due.size());
      $display("tls_client_hello_sni_extractor regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
